// File: rtl/core/multi_mask_edge_magnitude_stretch_macros.svh
// Assertion helpers used by the top-level file.
`ifndef MULTI_MASK_EDGE_MAGNITUDE_STRETCH_MACROS_SVH
`define MULTI_MASK_EDGE_MAGNITUDE_STRETCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MMES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mmes_pkg.sv
package mmes_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 7;
    localparam int MASK_TAPS  = 9;
    localparam int MASK_W     = 63;
    localparam int DIM_W      = 10;
    localparam int CNT_W      = 2;
    localparam int ACC_W      = 19;
    localparam int TAP_W      = 4;
    localparam int DIV_W      = 3;
    localparam int IDX_W      = 3;

    localparam logic [DIM_W-1:0] DIM_RESET   = 10'd512;
    localparam logic [CNT_W-1:0] COUNT_RESET = 2'd2;
    localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;
    localparam logic [TAP_W-1:0] TAP_LAST    = 4'd8;
    localparam logic [DIV_W-1:0] DIV_LAST    = 3'd7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_MASK_COUNT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_MASK_A       = 3'd3;
    localparam logic [IDX_W-1:0] REG_MASK_B       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_SHIFT,
        ST_LD_MAC,
        ST_LD_WR,
        ST_LD_ADV,
        ST_FE_RD,
        ST_FE_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic ld_shift;
        logic mac_step;
        logic ld_write;
        logic ld_adv;
        logic fe_prep;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fetch_empty;
        logic interior;
        logic mac_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/core/mmes_ctrl.sv
module mmes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              op,
    input  mmes_pkg::status_t status,
    output logic              in_stall,
    output mmes_pkg::cmd_t    cmd
);
    import mmes_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_FETCH)
                    begin
                        state_next = status.fetch_empty ? ST_OUT : ST_FE_RD;
                    end
                    else
                    begin
                        state_next = ST_LD_SHIFT;
                    end
                end
            end
            ST_LD_SHIFT: state_next = status.interior ? ST_LD_MAC : ST_LD_ADV;
            ST_LD_MAC:   if (status.mac_last) state_next = ST_LD_WR;
            ST_LD_WR:    state_next = ST_LD_ADV;
            ST_LD_ADV:   state_next = ST_IDLE;
            ST_FE_RD:    state_next = ST_FE_DIV;
            ST_FE_DIV:   if (status.div_last) state_next = ST_OUT;
            ST_OUT:      if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            ST_LD_SHIFT: cmd.ld_shift = 1'b1;
            ST_LD_MAC:   cmd.mac_step = 1'b1;
            ST_LD_WR:    cmd.ld_write = 1'b1;
            ST_LD_ADV:   cmd.ld_adv   = 1'b1;
            ST_FE_RD:    cmd.fe_prep  = 1'b1;
            ST_FE_DIV:   cmd.div_step = 1'b1;
            ST_OUT:      cmd.out_load = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/mmes_datapath.sv
module mmes_datapath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [mmes_pkg::IDX_W-1:0]          wr_index,
    input  logic [mmes_pkg::MASK_W-1:0]         wr_data,
    input  logic [mmes_pkg::PIX_W-1:0]          pixel,
    input  mmes_pkg::cmd_t                      cmd,
    input  logic                                out_stall,
    output mmes_pkg::status_t                   status,
    output logic                                out_valid,
    output logic [mmes_pkg::PIX_W-1:0]          value,
    output logic                                last,
    output logic                                empty_res
);
    import mmes_pkg::*;

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int HW    = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

    // configuration
    logic [DIM_W-1:0]  fw_reg;
    logic [DIM_W-1:0]  fh_reg;
    logic [CNT_W-1:0]  mc_reg;
    logic [MASK_W-1:0] ma_reg;
    logic [MASK_W-1:0] mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= DIM_RESET;
            fh_reg <= DIM_RESET;
            mc_reg <= COUNT_RESET;
            ma_reg <= '0;
            mb_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_FRAME_WIDTH:  fw_reg <= wr_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= wr_data[DIM_W-1:0];
                REG_MASK_COUNT:   mc_reg <= wr_data[CNT_W-1:0];
                REG_MASK_A:       ma_reg <= wr_data;
                REG_MASK_B:       mb_reg <= wr_data;
                default:          ;
            endcase
        end
    end

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (fw_reg < DIM_W'(3))
            w_eff = WW'(3);
        else if (WW'(fw_reg) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(fw_reg);
        if (fh_reg < DIM_W'(3))
            h_eff = HW'(3);
        else if (HW'(fh_reg) > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(fh_reg);
    end

    // control state
    logic [CB-1:0]    col_reg;
    logic [RB-1:0]    row_reg;
    logic [AW-1:0]    ridx_reg;
    logic [AW-1:0]    total_reg;
    logic             ready_reg;
    logic [PIX_W-1:0] min_reg;
    logic [PIX_W-1:0] max_reg;
    logic             empty_reg;
    logic             out_valid_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [DIV_W-1:0] dcnt_reg;
    logic [CB:0]      ls_fill_reg;

    // payload
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] ls0_rd_reg;
    logic [PIX_W-1:0] ls1_rd_reg;
    logic             ls_ok_reg;
    logic [PIX_W-1:0] ls0_pix;
    logic [PIX_W-1:0] ls1_pix;
    logic [PIX_W-1:0] store_rd_reg;
    logic [PIX_W-1:0] win_reg [MASK_TAPS];
    logic [AW-1:0]    idx_reg;
    logic signed [ACC_W-1:0] acc_a_reg;
    logic signed [ACC_W-1:0] acc_b_reg;
    logic [PIX_W-1:0] rem_reg;
    logic [PIX_W-1:0] quo_reg;
    logic [PIX_W-1:0] den_reg;
    logic             spec_reg;
    logic [PIX_W-1:0] spec_val_reg;
    logic [PIX_W-1:0] value_reg;
    logic             last_reg;
    logic             empty_res_reg;

    logic [PIX_W-1:0] ls0_mem [MAX_WIDTH];
    logic [PIX_W-1:0] ls1_mem [MAX_WIDTH];
    logic [PIX_W-1:0] mag_mem [DEPTH];

    // line store columns are always written from 0 upward, so a fill mark
    // tells which entries hold data; the rest read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ls0_rd_reg   <= ls0_mem[col_reg];
            ls1_rd_reg   <= ls1_mem[col_reg];
            ls_ok_reg    <= (CB+1)'(col_reg) < ls_fill_reg;
            store_rd_reg <= mag_mem[ridx_reg];
        end
        if (cmd.ld_shift)
        begin
            ls0_mem[col_reg] <= ls1_pix;
            ls1_mem[col_reg] <= pix_reg;
        end
    end

    always_comb
    begin
        ls0_pix = ls_ok_reg ? ls0_rd_reg : '0;
        ls1_pix = ls_ok_reg ? ls1_rd_reg : '0;
    end

    // magnitude of the finished window
    logic [ACC_W-1:0] abs_a;
    logic [ACC_W-1:0] abs_b;
    logic [ACC_W:0]   mag_sum;
    logic [PIX_W-1:0] mag8;

    always_comb
    begin
        abs_a   = acc_a_reg[ACC_W-1] ? ACC_W'(-acc_a_reg) : ACC_W'(acc_a_reg);
        abs_b   = acc_b_reg[ACC_W-1] ? ACC_W'(-acc_b_reg) : ACC_W'(acc_b_reg);
        mag_sum = (ACC_W+1)'(abs_a) + ((mc_reg >= CNT_W'(2)) ? (ACC_W+1)'(abs_b) : '0);
        mag8    = (mag_sum > (ACC_W+1)'(PIX_MAX)) ? PIX_MAX : mag_sum[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_write)
        begin
            mag_mem[idx_reg] <= mag8;
        end
    end

    // multiply-accumulate with one multiplier per mask, one tap per cycle for both masks
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [PIX_W:0]    win_sel;
    logic signed [15:0]       prod_a;
    logic signed [15:0]       prod_b;

    always_comb
    begin
        coef_a  = ma_reg[COEF_W*tap_reg +: COEF_W];
        coef_b  = mb_reg[COEF_W*tap_reg +: COEF_W];
        win_sel = {1'b0, win_reg[tap_reg]};
        prod_a  = coef_a * win_sel;
        prod_b  = coef_b * win_sel;
    end

    logic [AW-1:0] idx_calc;
    logic [AW-1:0] total_calc;
    logic [WW:0]   col_inc;
    logic [HW:0]   row_inc;
    logic          col_end;
    logic          row_end;
    logic [AW:0]   ridx_inc;
    logic          ridx_end;

    always_comb
    begin
        idx_calc   = AW'(AW'(row_reg - RB'(2)) * AW'(w_eff - WW'(2)))
                   + AW'(col_reg - CB'(2));
        total_calc = AW'(AW'(h_eff - HW'(2)) * AW'(w_eff - WW'(2)));
        col_inc    = (WW+1)'(col_reg) + (WW+1)'(1);
        row_inc    = (HW+1)'(row_reg) + (HW+1)'(1);
        col_end    = col_inc >= (WW+1)'(w_eff);
        row_end    = row_inc >= (HW+1)'(h_eff);
        ridx_inc   = (AW+1)'(ridx_reg) + (AW+1)'(1);
        ridx_end   = ridx_inc >= (AW+1)'(total_reg);
    end

    // window, accumulators, divider: no reset needed
    logic [PIX_W-1:0]   diff;
    logic [2*PIX_W-1:0] num;
    logic [PIX_W:0]     trial;
    logic               ge;

    always_comb
    begin
        diff  = store_rd_reg - min_reg;
        num   = {diff, {PIX_W{1'b0}}} - (2*PIX_W)'(diff);
        trial = {rem_reg, quo_reg[PIX_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg <= pixel;
        end
        if (cmd.ld_shift)
        begin
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= win_reg[k+3];
            end
            win_reg[6] <= ls0_pix;
            win_reg[7] <= ls1_pix;
            win_reg[8] <= pix_reg;
            idx_reg    <= idx_calc;
            acc_a_reg  <= '0;
            acc_b_reg  <= '0;
        end
        if (cmd.mac_step)
        begin
            acc_a_reg <= acc_a_reg + ACC_W'(prod_a);
            acc_b_reg <= acc_b_reg + ACC_W'(prod_b);
        end
        if (cmd.fe_prep)
        begin
            den_reg <= max_reg - min_reg;
            rem_reg <= num[2*PIX_W-1:PIX_W];
            quo_reg <= num[PIX_W-1:0];
            if (max_reg <= min_reg || store_rd_reg <= min_reg)
            begin
                spec_reg     <= 1'b1;
                spec_val_reg <= '0;
            end
            else if (store_rd_reg >= max_reg)
            begin
                spec_reg     <= 1'b1;
                spec_val_reg <= PIX_MAX;
            end
            else
            begin
                spec_reg     <= 1'b0;
                spec_val_reg <= '0;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? PIX_W'(trial - {1'b0, den_reg}) : trial[PIX_W-1:0];
            quo_reg <= {quo_reg[PIX_W-2:0], ge};
        end
        if (cmd.out_load)
        begin
            if (empty_reg)
            begin
                value_reg     <= '0;
                last_reg      <= 1'b0;
                empty_res_reg <= 1'b1;
            end
            else
            begin
                value_reg     <= spec_reg ? spec_val_reg : quo_reg;
                last_reg      <= ridx_end;
                empty_res_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            ridx_reg      <= '0;
            total_reg     <= '0;
            ready_reg     <= 1'b0;
            min_reg       <= PIX_MAX;
            max_reg       <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            tap_reg       <= '0;
            dcnt_reg      <= '0;
            ls_fill_reg   <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                empty_reg <= status.fetch_empty;
                dcnt_reg  <= '0;
            end
            if (cmd.ld_shift)
            begin
                tap_reg <= '0;
                if ((CB+1)'(col_reg) >= ls_fill_reg)
                begin
                    ls_fill_reg <= (CB+1)'(col_reg) + (CB+1)'(1);
                end
                // first pixel of a frame restarts the statistics
                if (row_reg == '0 && col_reg == '0)
                begin
                    min_reg   <= PIX_MAX;
                    max_reg   <= '0;
                    ready_reg <= 1'b0;
                end
            end
            if (cmd.mac_step && !status.mac_last)
            begin
                tap_reg <= tap_reg + TAP_W'(1);
            end
            if (cmd.ld_write)
            begin
                if (mag8 > max_reg) max_reg <= mag8;
                if (mag8 < min_reg) min_reg <= mag8;
            end
            if (cmd.ld_adv)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    if (row_end)
                    begin
                        row_reg   <= '0;
                        ready_reg <= 1'b1;
                        ridx_reg  <= '0;
                        total_reg <= total_calc;
                    end
                    else
                    begin
                        row_reg <= row_reg + RB'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + CB'(1);
                end
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DIV_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (empty_reg)
                begin
                    ready_reg <= 1'b0;
                end
                else
                begin
                    ridx_reg <= ridx_inc[AW-1:0];
                    if (ridx_end) ready_reg <= 1'b0;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.fetch_empty = !ready_reg || (ridx_reg >= total_reg);
        status.interior    = (row_reg >= RB'(2)) && (col_reg >= CB'(2));
        status.mac_last    = tap_reg == TAP_LAST;
        status.div_last    = dcnt_reg == DIV_LAST;
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign last      = last_reg;
    assign empty_res = empty_res_reg;

endmodule

// File: rtl/core/multi_mask_edge_magnitude_stretch.sv
// Channel  Handshake            Payload
// input    in_valid / in_stall  op, pixel
// output   out_valid / out_stall value, last, empty_res
// config   wr_en                wr_index, wr_data
//
// A load shifts the window; at an interior pixel it walks the nine taps, one
// multiply-accumulate per mask side by side, then it advances. A fetch runs
// memory read, bit-serial divider and output, or goes straight to output when
// nothing is left to read. Reset is asynchronous; memories need no clearing
// pass. A result waits in the output register while out_stall is high; the
// next item is taken meanwhile, and a fetch then holds until it drains.
`include "multi_mask_edge_magnitude_stretch_macros.svh"

module multi_mask_edge_magnitude_stretch #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [mmes_pkg::PIX_W-1:0]  pixel,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mmes_pkg::PIX_W-1:0]  value,
    output logic                        last,
    output logic                        empty_res,
    input  logic                        wr_en,
    input  logic [mmes_pkg::IDX_W-1:0]  wr_index,
    input  logic [mmes_pkg::MASK_W-1:0] wr_data
);
    import mmes_pkg::*;

    cmd_t    cmd;
    status_t status;

    mmes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    mmes_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .value     (value),
        .last      (last),
        .empty_res (empty_res)
    );

    `MMES_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "item taken while busy")
    `MMES_ASSERT_NOW(a_empty_zero, out_valid && empty_res, value == '0 && !last, "empty item not zero")
    `MMES_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "result not presented")

endmodule

// File: verif/multi_mask_edge_magnitude_stretch_tb.sv
module multi_mask_edge_magnitude_stretch_tb;
    import mmes_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             last;
        logic             empty_res;
    } stretch_result_t;

    class magnitude_scoreboard;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic [CNT_W-1:0]  count_reg;
        logic [MASK_W-1:0] mask_a;
        logic [MASK_W-1:0] mask_b;
        logic [7:0]        line_top[512];
        logic [7:0]        line_mid[512];
        logic [7:0]        win[3][3];
        logic [7:0]        mag_store[262144];
        logic [7:0]        fmin;
        logic [7:0]        fmax;
        int                row;
        int                col;
        int                rd_idx;
        int                rd_total;
        bit                ready;
        stretch_result_t   expected_pixels[$];
        int                errors;

        function new();
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            count_reg  = COUNT_RESET;
            mask_a     = '0;
            mask_b     = '0;
            foreach (line_top[i])
            begin
                line_top[i] = '0;
                line_mid[i] = '0;
            end
            foreach (win[i, j])
                win[i][j] = '0;
            fmin     = 8'd255;
            fmax     = '0;
            row      = 0;
            col      = 0;
            rd_idx   = 0;
            rd_total = 0;
            ready    = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [MASK_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
                REG_MASK_COUNT:   count_reg  = data[CNT_W-1:0];
                REG_MASK_A:       mask_a     = data;
                REG_MASK_B:       mask_b     = data;
                default: ;
            endcase
        endfunction

        function int eff_dim(logic [DIM_W-1:0] v);
            if (v < 3)
                return 3;
            if (v > 512)
                return 512;
            return v;
        endfunction

        function int response(logic [MASK_W-1:0] m);
            int acc;
            logic signed [COEF_W-1:0] c;
            acc = 0;
            for (int cx = 0; cx < 3; cx++)
                for (int cy = 0; cy < 3; cy++)
                begin
                    c = m[7*(cx*3+cy) +: 7];
                    acc += int'(c) * int'(win[cx][cy]);
                end
            return acc < 0 ? -acc : acc;
        endfunction

        function void load_pixel(logic [7:0] p);
            int w;
            int h;
            int mag;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            if (row == 0 && col == 0)
            begin
                fmin  = 8'd255;
                fmax  = '0;
                ready = 0;
            end
            for (int cy = 0; cy < 3; cy++)
            begin
                win[0][cy] = win[1][cy];
                win[1][cy] = win[2][cy];
            end
            win[2][0] = line_top[col];
            win[2][1] = line_mid[col];
            win[2][2] = p;
            line_top[col] = line_mid[col];
            line_mid[col] = p;
            if (row >= 2 && col >= 2)
            begin
                mag = response(mask_a);
                if (count_reg != 2'd0 && count_reg != 2'd1)
                    mag += response(mask_b);
                if (mag > 255)
                    mag = 255;
                if (mag > fmax)
                    fmax = 8'(mag);
                if (mag < fmin)
                    fmin = 8'(mag);
                mag_store[(row-2)*(w-2) + (col-2)] = 8'(mag);
            end
            if (col + 1 >= w)
            begin
                col = 0;
                if (row + 1 >= h)
                begin
                    row      = 0;
                    ready    = 1;
                    rd_idx   = 0;
                    rd_total = (h-2)*(w-2);
                end
                else
                    row++;
            end
            else
                col++;
        endfunction

        function void note_item(logic op_in, logic [7:0] p);
            stretch_result_t r;
            int v;
            if (op_in == OP_LOAD)
            begin
                load_pixel(p);
                return;
            end
            r.value = '0;
            r.last = 1'b0;
            r.empty_res = 1'b0;
            if (!ready || rd_idx >= rd_total)
            begin
                ready = 0;
                r.empty_res = 1'b1;
            end
            else
            begin
                v = mag_store[rd_idx];
                if (fmax <= fmin || v <= fmin)
                    r.value = '0;
                else if (v >= fmax)
                    r.value = 8'd255;
                else
                    r.value = 8'((v - fmin) * 255 / (fmax - fmin));
                r.last = (rd_idx + 1 >= rd_total);
                rd_idx++;
                if (rd_idx >= rd_total)
                    ready = 0;
            end
            expected_pixels.push_back(r);
        endfunction

        function void check_result(logic [7:0] v, logic l, logic e);
            stretch_result_t x;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected item value=%0d last=%0d empty_res=%0d",
                         $time, v, l, e);
                errors++;
                return;
            end
            x = expected_pixels.pop_front();
            if (v !== x.value)
            begin
                $display("%0t: value expected %0d actual %0d", $time, x.value, v);
                errors++;
            end
            if (l !== x.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, x.last, l);
                errors++;
            end
            if (e !== x.empty_res)
            begin
                $display("%0t: empty_res expected %0d actual %0d", $time, x.empty_res, e);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [PIX_W-1:0]  pixel;
    logic              out_valid;
    logic              out_stall;
    logic [PIX_W-1:0]  value;
    logic              last;
    logic              empty_res;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [MASK_W-1:0] wr_data;

    magnitude_scoreboard sb = new();
    bit quiet;
    bit hold_req;
    int hold_left;

    multi_mask_edge_magnitude_stretch i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .last      (last),
        .empty_res (empty_res),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stall, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(value, last, empty_res);
            if (hold_req)
            begin
                hold_req  = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    task automatic send_item(logic o, logic [7:0] p);
        if (!quiet && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 11);
        end
        in_valid <= 1'b1;
        op       <= o;
        pixel    <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(o, p);
    endtask

    // Only called with the loader at a frame boundary; it waits until nothing is in flight.
    task automatic write_regs(int w, int h, int cnt, logic [62:0] ma, logic [62:0] mb);
        logic [62:0] vals[5];
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        vals = '{63'(w), 63'(h), 63'(cnt), ma, mb};
        for (int i = 0; i < 5; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= i[IDX_W-1:0];
            wr_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(i[IDX_W-1:0], vals[i]);
        end
        wr_en <= 1'b0;
    endtask

    function automatic logic [62:0] build_mask(int mode);
        logic [62:0] m;
        logic signed [6:0] c;
        m = 63'({$urandom, $urandom});
        if (mode == 0)
            for (int i = 0; i < 9; i++)
            begin
                c = 7'($urandom_range(6) - 3);
                m[7*i +: 7] = c;
            end
        else if (mode == 1)
            for (int i = 0; i < 9; i++)
            begin
                c = 7'((i / 3) - 1);
                m[7*i +: 7] = c;
            end
        return m;
    endfunction

    // pattern: 0 random, 1 ramp, 2 flat, 3 extremes
    task automatic load_frame(int pattern, bit noise);
        int w;
        int h;
        logic [7:0] base;
        logic [7:0] p;
        w = sb.eff_dim(sb.width_reg);
        h = sb.eff_dim(sb.height_reg);
        base = 8'($urandom);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                case (pattern)
                    0: p = 8'($urandom);
                    1: p = 8'(base + r*3 + c*5);
                    2: p = base;
                    default: p = ((r + c) % 2) ? 8'd255 : 8'd0;
                endcase
                if (noise && $urandom_range(99) < 5)
                    send_item(OP_FETCH, 8'($urandom));
                send_item(OP_LOAD, p);
            end
    endtask

    task automatic fetch_n(int n);
        for (int i = 0; i < n; i++)
            send_item(OP_FETCH, 8'($urandom));
    endtask

    initial
    begin
        int w;
        int h;
        int extra;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = OP_LOAD;
        pixel    = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        quiet    = 0;
        hold_req = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fetch with nothing, saturated masks, flat output, clamped registers
        send_item(OP_FETCH, 8'hA5);
        write_regs(3, 3, 1, {9{7'h40}}, {9{7'h3F}});
        load_frame(3, 0);
        fetch_n(2);
        write_regs(0, 4, 3, build_mask(1), build_mask(0));
        load_frame(3, 0);
        fetch_n(3);
        write_regs(2, 5, 0, build_mask(0), {9{7'h40}});
        load_frame(1, 0);
        send_item(OP_FETCH, 8'h00);
        load_frame(2, 0);
        fetch_n(4);

        // wide and tall frames
        write_regs(48, 3, 2, build_mask(0), build_mask(1));
        load_frame(0, 0);
        fetch_n(47);
        write_regs(3, 20, 2, build_mask(1), build_mask(0));
        load_frame(1, 0);
        fetch_n(19);

        for (int f = 0; f < 14; f++)
        begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 8);
            write_regs(($urandom_range(9) == 0) ? $urandom_range(2) : w, h,
                       $urandom_range(3), build_mask($urandom_range(2)),
                       build_mask($urandom_range(2)));
            quiet = (f >= 5 && f < 8);
            load_frame($urandom_range(3), $urandom_range(3) == 0);
            if (f == 3)
                hold_req = 1;
            w = sb.eff_dim(sb.width_reg);
            h = sb.eff_dim(sb.height_reg);
            extra = $urandom_range(2);
            // sometimes break off early so the next frame drops the rest
            if ($urandom_range(4) == 0)
                fetch_n($urandom_range((w-2)*(h-2)));
            else
                fetch_n((w-2)*(h-2) + extra);
        end
        quiet = 0;
        in_valid <= 1'b0;

        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
